### src/cpid_pkg.sv
// Shared types and constants for the cascaded PID phase-shift controller.
package cpid_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_VOLTAGE_KP = 3'd0,
        CFG_VOLTAGE_KI = 3'd1,
        CFG_VOLTAGE_KD = 3'd2,
        CFG_CURRENT_KP = 3'd3,
        CFG_CURRENT_KI = 3'd4,
        CFG_DUTY_CEIL  = 3'd5,
        CFG_PHASE_SPAN = 3'd6,
        CFG_RAMP_START = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [17:0] DUTY_CEIL_RST = 18'd131072;

    // Terms issued to the shared multiplier per loop
    localparam int V_TERMS = 5;
    localparam int I_TERMS = 2;

    // Products issued to the shared multiplier
    typedef enum logic [3:0] {
        MUL_STEP = 4'd0,   // target times ramp-divisor reciprocal
        MUL_V0   = 4'd1,   // (kp + ki) * e
        MUL_V1   = 4'd2,   // (ki - kp) * e[n-1]
        MUL_V2   = 4'd3,   // kd * e
        MUL_V3   = 4'd4,   // 2 kd * e[n-1], subtracted
        MUL_V4   = 4'd5,   // kd * e[n-2]
        MUL_I0   = 4'd6,   // (kp + ki) * ie
        MUL_I1   = 4'd7,   // (ki - kp) * ie[n-1]
        MUL_PH   = 4'd8    // duty * phase_span
    } t_mul_op;

    typedef struct packed {
        logic [14:0] voltage_kp;
        logic [14:0] voltage_ki;
        logic [14:0] voltage_kd;
        logic [14:0] current_kp;
        logic [14:0] current_ki;
        logic [17:0] duty_ceiling;
        logic [15:0] phase_span;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic    in_load;    // capture input beat
        logic    mul_en;     // issue a product
        t_mul_op mul_op;
        logic    ramp_upd;   // advance soft-start ramp, load voltage error
        logic    v_upd;      // clamp current command, shift voltage history
        logic    i_upd;      // clamp duty, shift current history
        logic    out_load;   // load result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;      // result register full and not drained this cycle
    } t_dp_sts;

endpackage

### src/cpid_regs.sv
// Configuration register file for the cascaded PID phase-shift controller.
module cpid_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cpid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output cpid_pkg::t_cfg                      o_cfg
);
    import cpid_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voltage_kp   <= '0;
            r_cfg.voltage_ki   <= '0;
            r_cfg.voltage_kd   <= '0;
            r_cfg.current_kp   <= '0;
            r_cfg.current_ki   <= '0;
            r_cfg.duty_ceiling <= DUTY_CEIL_RST;
            r_cfg.phase_span   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_VOLTAGE_KP: r_cfg.voltage_kp   <= i_cfg_data[14:0];
                CFG_VOLTAGE_KI: r_cfg.voltage_ki   <= i_cfg_data[14:0];
                CFG_VOLTAGE_KD: r_cfg.voltage_kd   <= i_cfg_data[14:0];
                CFG_CURRENT_KP: r_cfg.current_kp   <= i_cfg_data[14:0];
                CFG_CURRENT_KI: r_cfg.current_ki   <= i_cfg_data[14:0];
                CFG_DUTY_CEIL:  r_cfg.duty_ceiling <= i_cfg_data[17:0];
                CFG_PHASE_SPAN: r_cfg.phase_span   <= i_cfg_data[15:0];
                // ramp start only matters at reset, where it clears too:
                // the ramp always restarts from zero, so drop the write
                CFG_RAMP_START: r_cfg <= r_cfg;
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/cpid_ctrl.sv
// Sequencer for the cascaded PID phase-shift controller datapath.
module cpid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cpid_pkg::t_dp_sts i_sts,
    output cpid_pkg::t_dp_cmd o_cmd
);
    import cpid_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_STEP   = 11'b000_0000_0010,
        S_RAMP   = 11'b000_0000_0100,
        S_VMUL   = 11'b000_0000_1000,
        S_VACC   = 11'b000_0001_0000,
        S_VCLAMP = 11'b000_0010_0000,
        S_IMUL   = 11'b000_0100_0000,
        S_IACC   = 11'b000_1000_0000,
        S_ICLAMP = 11'b001_0000_0000,
        S_PMUL   = 11'b010_0000_0000,
        S_POUT   = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_op = MUL_STEP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_STEP;
                n_state = S_RAMP;
            end
            S_RAMP: begin
                o_cmd.ramp_upd = 1'b1;
                n_cnt   = '0;
                n_state = S_VMUL;
            end
            S_VMUL: begin
                o_cmd.mul_en = 1'b1;
                case (r_cnt)
                    3'd0:    o_cmd.mul_op = MUL_V0;
                    3'd1:    o_cmd.mul_op = MUL_V1;
                    3'd2:    o_cmd.mul_op = MUL_V2;
                    3'd3:    o_cmd.mul_op = MUL_V3;
                    default: o_cmd.mul_op = MUL_V4;
                endcase
                if (r_cnt == 3'(V_TERMS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_VACC;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_VACC: begin
                n_state = S_VCLAMP;
            end
            S_VCLAMP: begin
                o_cmd.v_upd = 1'b1;
                n_state = S_IMUL;
            end
            S_IMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = (r_cnt == 3'd0) ? MUL_I0 : MUL_I1;
                if (r_cnt == 3'(I_TERMS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IACC;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_IACC: begin
                n_state = S_ICLAMP;
            end
            S_ICLAMP: begin
                o_cmd.i_upd = 1'b1;
                n_state = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_PH;
                n_state = S_POUT;
            end
            S_POUT: begin
                // hold until the result register frees up
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### src/cpid_dp.sv
// Datapath of the cascaded PID phase-shift controller: ramp, shared multiplier, loops.
module cpid_dp #(
    parameter int ADC_BITS     = 12,
    parameter int RAMP_DIVISOR = 200
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpid_pkg::t_dp_cmd i_cmd,
    output cpid_pkg::t_dp_sts o_sts,
    input  cpid_pkg::t_cfg    i_cfg,
    input  logic [11:0]       i_adc_vout,
    input  logic [11:0]       i_adc_iout,
    input  logic [17:0]       i_voltage_target,
    input  logic [17:0]       i_current_limit,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [15:0]       o_phase_shift,
    output logic [17:0]       o_current_command,
    output logic              o_softstart_done
);
    import cpid_pkg::*;

    // ADC scaling to Q17
    localparam int          Q_SHIFT  = 17 - ADC_BITS;
    localparam logic [11:0] ADC_MASK = (ADC_BITS >= 12) ? 12'hFFF :
                                       12'((64'd1 << ADC_BITS) - 64'd1);
    // Ramp step by reciprocal: floor(t / D) = (t * M) >> K, exact for 18-bit t
    localparam int              DIV_LOG = $clog2(RAMP_DIVISOR);
    localparam int              DIV_K   = 18 + DIV_LOG;
    localparam longint unsigned DIV_M   =
        ((64'd1 << DIV_K) + 64'(RAMP_DIVISOR) - 64'd1) / 64'(RAMP_DIVISOR);
    localparam logic [18:0]     DIV_M19 = 19'(DIV_M);
    localparam logic [17:0]     MAX18   = 18'h3FFFF;

    function automatic logic [17:0] clamp_hi(input logic signed [27:0] v,
                                             input logic [17:0] hi);
        logic [17:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({10'b0, hi})) begin
            res = hi;
        end else begin
            res = v[17:0];
        end
        return res;
    endfunction

    // Captured beat
    logic [16:0] r_vq, r_iq;
    logic [17:0] r_target, r_limit;
    // Loop state
    logic [17:0]        r_ramp;
    logic               r_finished;
    logic signed [18:0] r_ve, r_lve, r_ove, r_ie, r_lie;
    logic [17:0]        r_lcmd, r_lduty;
    // Arithmetic
    logic signed [39:0] r_prod;
    t_mul_op            r_prod_op;
    logic               r_prod_vld;
    logic signed [27:0] r_acc;
    // Result register
    logic        r_out_vld;
    logic [15:0] r_out_phase;
    logic [17:0] r_out_cmd;
    logic        r_out_done;

    logic [16:0] w_vq, w_iq;
    assign w_vq = {5'b0, i_adc_vout & ADC_MASK} << Q_SHIFT;
    assign w_iq = {5'b0, i_adc_iout & ADC_MASK} << Q_SHIFT;

    // Gain combinations
    logic [15:0]        w_vkp_ki, w_ckp_ki, w_vkd2;
    logic signed [16:0] w_vki_kp, w_cki_kp;
    assign w_vkp_ki = {1'b0, i_cfg.voltage_kp} + {1'b0, i_cfg.voltage_ki};
    assign w_ckp_ki = {1'b0, i_cfg.current_kp} + {1'b0, i_cfg.current_ki};
    assign w_vkd2   = {i_cfg.voltage_kd, 1'b0};
    assign w_vki_kp = $signed({2'b0, i_cfg.voltage_ki}) - $signed({2'b0, i_cfg.voltage_kp});
    assign w_cki_kp = $signed({2'b0, i_cfg.current_ki}) - $signed({2'b0, i_cfg.current_kp});

    // Operand select for the shared multiplier
    logic signed [19:0] w_mul_a, w_mul_b;
    logic signed [39:0] w_prod;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_STEP: begin
                w_mul_a = $signed({2'b0, r_target});
                w_mul_b = $signed({1'b0, DIV_M19});
            end
            MUL_V0: begin
                w_mul_a = {r_ve[18], r_ve};
                w_mul_b = $signed({4'b0, w_vkp_ki});
            end
            MUL_V1: begin
                w_mul_a = {r_lve[18], r_lve};
                w_mul_b = {{3{w_vki_kp[16]}}, w_vki_kp};
            end
            MUL_V2: begin
                w_mul_a = {r_ve[18], r_ve};
                w_mul_b = $signed({5'b0, i_cfg.voltage_kd});
            end
            MUL_V3: begin
                w_mul_a = {r_lve[18], r_lve};
                w_mul_b = $signed({4'b0, w_vkd2});
            end
            MUL_V4: begin
                w_mul_a = {r_ove[18], r_ove};
                w_mul_b = $signed({5'b0, i_cfg.voltage_kd});
            end
            MUL_I0: begin
                w_mul_a = {r_ie[18], r_ie};
                w_mul_b = $signed({4'b0, w_ckp_ki});
            end
            MUL_I1: begin
                w_mul_a = {r_lie[18], r_lie};
                w_mul_b = {{3{w_cki_kp[16]}}, w_cki_kp};
            end
            MUL_PH: begin
                w_mul_a = $signed({2'b0, r_lduty});
                w_mul_b = $signed({4'b0, i_cfg.phase_span});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Scale the registered product into a loop term (floor shift per term)
    logic signed [39:0] w_sh13, w_sh12;
    logic signed [27:0] w_term;
    logic               w_term_en;
    assign w_sh13 = r_prod >>> 13;
    assign w_sh12 = r_prod >>> 12;

    always_comb begin
        w_term_en = r_prod_vld;
        case (r_prod_op)
            MUL_V0, MUL_V1, MUL_V2, MUL_V4: w_term = w_sh13[27:0];
            MUL_V3:                         w_term = -w_sh13[27:0];
            MUL_I0, MUL_I1:                 w_term = w_sh12[27:0];
            default: begin
                w_term    = '0;
                w_term_en = 1'b0;
            end
        endcase
    end

    // Soft-start ramp
    logic [39:0]        w_step_full;
    logic [17:0]        w_step, w_up, w_floor, w_down, n_ramp;
    logic [18:0]        w_sum, w_dif;
    logic               w_ge, w_over, n_done;
    logic signed [18:0] w_ve;

    assign w_step_full = r_prod >>> DIV_K;
    assign w_step      = w_step_full[17:0];
    assign w_sum       = {1'b0, r_ramp} + {1'b0, w_step};
    assign w_dif       = {1'b0, r_ramp} - {1'b0, w_step};
    assign w_up        = w_sum[18] ? MAX18 : w_sum[17:0];
    assign w_floor     = w_dif[18] ? 18'd0 : w_dif[17:0];
    assign w_down      = (w_floor < r_target) ? r_target : w_floor;
    assign w_ge        = (r_ramp >= {1'b0, r_vq});
    assign w_over      = (r_ramp > r_target);

    always_comb begin
        n_done = 1'b0;
        if (w_ge) begin
            if (w_over) begin
                n_ramp = r_target;
                n_done = 1'b1;
            end else begin
                n_ramp = w_up;
            end
        end else begin
            n_ramp = w_down;
        end
    end

    assign w_ve = $signed({1'b0, n_ramp}) - $signed({2'b0, r_vq});

    // Loop clamps
    logic [17:0] w_cmd, w_duty;
    assign w_cmd  = clamp_hi(r_acc, r_limit);
    assign w_duty = clamp_hi(r_acc, i_cfg.duty_ceiling);

    // Phase scaling with saturation
    logic [39:0] w_ph;
    logic [15:0] w_phase;
    assign w_ph    = r_prod >>> 17;
    assign w_phase = (|w_ph[39:16]) ? 16'hFFFF : w_ph[15:0];

    // Control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp     <= '0;
            r_finished <= 1'b0;
            r_lve      <= '0;
            r_ove      <= '0;
            r_lcmd     <= '0;
            r_lie      <= '0;
            r_lduty    <= '0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
            if (i_cmd.ramp_upd) begin
                r_ramp     <= n_ramp;
                r_finished <= r_finished | n_done;
            end
            if (i_cmd.v_upd) begin
                r_lcmd <= w_cmd;
                r_ove  <= r_lve;
                r_lve  <= r_ve;
            end
            if (i_cmd.i_upd) begin
                r_lduty <= w_duty;
                r_lie   <= r_ie;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_vq     <= w_vq;
            r_iq     <= w_iq;
            r_target <= i_voltage_target;
            r_limit  <= i_current_limit;
        end
        if (i_cmd.mul_en) begin
            r_prod    <= w_prod;
            r_prod_op <= i_cmd.mul_op;
        end
        if (i_cmd.ramp_upd) begin
            r_ve  <= w_ve;
            r_acc <= $signed({10'b0, r_lcmd});
        end else if (i_cmd.v_upd) begin
            r_ie  <= $signed({1'b0, w_cmd}) - $signed({2'b0, r_iq});
            r_acc <= $signed({10'b0, r_lduty});
        end else if (w_term_en) begin
            r_acc <= r_acc + w_term;
        end
        if (i_cmd.out_load) begin
            r_out_phase <= w_phase;
            r_out_cmd   <= r_lcmd;
            r_out_done  <= r_finished;
        end
    end

    assign o_sts.out_busy    = r_out_vld & ~i_out_ready;
    assign o_out_valid       = r_out_vld;
    assign o_phase_shift     = r_out_phase;
    assign o_current_command = r_out_cmd;
    assign o_softstart_done  = r_out_done;

endmodule

### src/cascaded_pid_phase_shift_controller_top.sv
// Top level of the cascaded PID phase-shift controller.
// Input beats are taken only while the sequencer is idle, so each beat is carried to the
//   result register before the next is accepted; one shared 20x20 multiplier carries nine
//   products per tick (ramp step, five voltage terms, two current terms, phase).
// The result register frees the input side: a new beat is taken while a result waits.
// Reset (synchronous, active low): gains clear, duty ceiling goes to full scale,
//   ramp, error histories, command and duty clear, soft-start flag drops.
module cascaded_pid_phase_shift_controller_top #(
    parameter int ADC_BITS     = 12,
    parameter int RAMP_DIVISOR = 200
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cpid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel: one sample pair per control tick
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [11:0]                     i_adc_vout,
    input  logic [11:0]                     i_adc_iout,
    input  logic [17:0]                     i_voltage_target,
    input  logic [17:0]                     i_current_limit,
    // output channel: one result per tick
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [15:0]                     o_phase_shift,
    output logic [17:0]                     o_current_command,
    output logic                            o_softstart_done
);
    import cpid_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Gains, duty ceiling and phase span; the user must write them only while idle, the block does not enforce it
    cpid_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Sequencer: accept a beat, step the multiplier through the ramp step,
    // voltage PID terms, current PI terms and phase product, then hand the
    // result to the output register once it is free
    cpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: Q17 scaling, soft-start ramp, shared multiplier with
    // accumulator, loop clamps, history registers and result register
    cpid_dp #(
        .ADC_BITS     (ADC_BITS),
        .RAMP_DIVISOR (RAMP_DIVISOR)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg             (w_cfg),
        .i_adc_vout        (i_adc_vout),
        .i_adc_iout        (i_adc_iout),
        .i_voltage_target  (i_voltage_target),
        .i_current_limit   (i_current_limit),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_phase_shift     (o_phase_shift),
        .o_current_command (o_current_command),
        .o_softstart_done  (o_softstart_done)
    );

endmodule
